[hw/rtl/hrcg_pkg.sv]
// shared constants, types and field arithmetic for the heavy-row coefficient generator
package hrcg_pkg;

	// pipeline depth, entry register to output register
	localparam int STAGES = 7;

	// column bits folded into the remainder per divider stage
	localparam int DIV_DIGIT = 4;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_HEAVY_ROW_COUNT = 2'd0,
		REG_COEFF_FAMILY    = 2'd1,
		REG_HASH_SEED       = 2'd2
	} reg_index_t;

	localparam logic [7:0]  HEAVY_ROW_COUNT_RST = 8'd12;
	localparam logic        COEFF_FAMILY_RST    = 1'b0;
	localparam logic [63:0] HASH_SEED_RST       = 64'd0;

	// cauchy window is WINDOW_BASE minus the heavy row count
	localparam logic [8:0] WINDOW_BASE = 9'd256;

	// hash mixing constants
	localparam logic [63:0] COL_MULT  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] ROW_MULT  = 64'hd6e8feb86659fd93;
	localparam logic [63:0] MIX_SALT  = 64'h6865617679686173;
	localparam logic [63:0] MIX_MULT1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MULT2 = 64'h94d049bb133111eb;
	localparam int MIX_SHIFT_A = 30;
	localparam int MIX_SHIFT_B = 27;
	localparam int MIX_SHIFT_C = 31;

	// only the low ZW bits of the last product reach the output byte
	localparam int ZW = MIX_SHIFT_C + 8;
	localparam int XW = ZW - 32;

	typedef logic [255:0][7:0] inv_table_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] poly);
		logic [8:0] aa;
		logic [7:0] bb;
		logic [7:0] acc;
		acc = '0;
		aa = {1'b0, a};
		bb = b;
		for (int i = 0; i < 8; i++) begin
			if (bb[0]) begin
				acc = acc ^ aa[7:0];
			end
			bb = bb >> 1;
			aa = {aa[7:0], 1'b0};
			if (aa[8]) begin
				aa = aa ^ poly;
			end
			aa = {1'b0, aa[7:0]};
		end
		return acc;
	endfunction

	// a^254 for every a, evaluated at elaboration
	function automatic inv_table_t gf_inv_table(input logic [8:0] poly);
		inv_table_t tab;
		logic [7:0] res;
		logic [7:0] base;
		logic [7:0] e;
		for (int a = 0; a < 256; a++) begin
			res = 8'd1;
			base = 8'(a);
			e = 8'd254;
			for (int k = 0; k < 8; k++) begin
				if (e[k]) begin
					res = gf_mul(res, base, poly);
				end
				base = gf_mul(base, base, poly);
			end
			tab[a] = res;
		end
		return tab;
	endfunction

endpackage

[hw/rtl/hrcg_hash.sv]
// splitmix64 hash datapath, six pipeline stages plus the final byte fold
module hrcg_hash (
	input  logic                        clk,
	input  logic [hrcg_pkg::STAGES-2:0] stage_en,
	input  logic [6:0]                  row_num,
	input  logic [15:0]                 column_index,
	input  logic [63:0]                 seed,
	output logic [7:0]                  hash_coef
);
	import hrcg_pkg::*;

	logic [47:0] ca_s1;
	logic [31:0] cb_s1;
	logic [63:0] rp_s1;
	logic [63:0] x1_s2;
	logic [63:0] all_s3;
	logic [31:0] alh_s3;
	logic [31:0] x1hi_s3;
	logic [63:0] sum_s4;
	logic [31:0] ahl_s4;
	logic [63:0] y2_s5;
	logic [ZW-1:0] bll_s6;
	logic [XW-1:0] bx_s6;

	logic [63:0] x0;
	logic [63:0] y;
	logic [63:0] bll_full;
	logic [ZW-1:0] z;
	logic [7:0] fold;

	always_comb begin
		x0 = seed ^ (64'(ca_s1) + {cb_s1, 32'd0}) ^ rp_s1 ^ MIX_SALT;
		y = sum_s4 + {ahl_s4, 32'd0};
		bll_full = 64'(y2_s5[31:0]) * 64'(MIX_MULT2[31:0]);
		z = bll_s6 + {bx_s6, 32'd0};
		fold = z[7:0] ^ z[MIX_SHIFT_C+7:MIX_SHIFT_C];
		hash_coef = (fold == 8'd0) ? 8'd1 : fold;
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			ca_s1 <= 48'(column_index) * 48'(COL_MULT[31:0]);
			cb_s1 <= 32'(column_index) * COL_MULT[63:32];
			rp_s1 <= 64'(row_num) * ROW_MULT;
		end
		if (stage_en[1]) begin
			x1_s2 <= x0 ^ (x0 >> MIX_SHIFT_A);
		end
		if (stage_en[2]) begin
			all_s3 <= 64'(x1_s2[31:0]) * 64'(MIX_MULT1[31:0]);
			alh_s3 <= x1_s2[31:0] * MIX_MULT1[63:32];
			x1hi_s3 <= x1_s2[63:32];
		end
		if (stage_en[3]) begin
			sum_s4 <= all_s3 + {alh_s3, 32'd0};
			ahl_s4 <= x1hi_s3 * MIX_MULT1[31:0];
		end
		if (stage_en[4]) begin
			y2_s5 <= y ^ (y >> MIX_SHIFT_B);
		end
		if (stage_en[5]) begin
			bll_s6 <= bll_full[ZW-1:0];
			// cross products only matter in the bits just above 32
			bx_s6 <= XW'(y2_s5[XW-1:0] * MIX_MULT2[32+XW-1:32])
				+ XW'(y2_s5[32+XW-1:32] * MIX_MULT2[XW-1:0]);
		end
	end

endmodule

[hw/rtl/heavy_row_coefficient_generator_top.sv]
// heavy-row coefficient generator: config registers, control, cauchy path and output stage
//
// Input channel (in_valid/in_ready) takes a heavy row number and a column index; the
// output channel (out_valid/out_ready) returns an 8-bit gf(256) coefficient and a
// row_error flag, one item out for each item in, in order.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken:
// index 0 heavy row count, 1 coefficient family, 2 hash seed; other indexes are ignored.
// Write configuration only while no item is in flight.
// Seven register stages, from the one loaded by the edge that accepts an item to the
// output register behind out_valid; one item is accepted per cycle while not stalled.
// The depth is set by the two 64-bit hash multiplies, cut into 32-bit partial
// products, and by the column remainder, four bits per stage over four stages.
// A stalled receiver holds the output register; each stage keeps taking items while
// a stage ahead of it is empty, so bubbles close up and nothing is lost or repeated.
// Reset empties the pipeline and sets heavy row count 12, cauchy family, seed 0.
module heavy_row_coefficient_generator_top #(
	parameter int FIELD_POLY = 333
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  row_num,
	input  logic [15:0] column_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  coefficient,
	output logic        row_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import hrcg_pkg::*;

	localparam inv_table_t INV_TAB = gf_inv_table(9'(FIELD_POLY));

	logic [7:0]  heavy_row_count_q;
	logic        coeff_family_q;
	logic [63:0] hash_seed_q;

	logic [STAGES-1:0] stage_valid_q;
	logic [STAGES-1:0] stage_en;

	logic [8:0] window;
	logic [7:0] hash_coef;
	logic [7:0] cauchy_x;

	logic [6:0]  row_s1, row_s2, row_s3, row_s4, row_s5;
	logic        err_s1, err_s2, err_s3, err_s4, err_s5, err_s6;
	logic [15:0] col_s1;
	logic [11:0] col_s2;
	logic [7:0]  col_s3;
	logic [3:0]  col_s4;
	logic [7:0]  rem_s2, rem_s3, rem_s4, rem_s5;
	logic [7:0]  inv_s6;
	logic [7:0]  coefficient_s7;
	logic        row_error_s7;

	// restoring remainder over one digit of the column
	function automatic logic [7:0] rem_digit(input logic [7:0] r,
			input logic [DIV_DIGIT-1:0] bits, input logic [8:0] w);
		logic [8:0] t;
		logic [7:0] acc;
		acc = r;
		for (int k = DIV_DIGIT - 1; k >= 0; k--) begin
			t = {acc, bits[k]};
			if (t >= w) begin
				t = t - w;
			end
			acc = t[7:0];
		end
		return acc;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heavy_row_count_q <= HEAVY_ROW_COUNT_RST;
			coeff_family_q <= COEFF_FAMILY_RST;
			hash_seed_q <= HASH_SEED_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HEAVY_ROW_COUNT: begin
					heavy_row_count_q <= cfg_data[7:0];
				end
				REG_COEFF_FAMILY: begin
					coeff_family_q <= cfg_data[0];
				end
				REG_HASH_SEED: begin
					hash_seed_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// a stage loads when it is empty or the stage ahead of it moves
	always_comb begin
		stage_en[STAGES-1] = !stage_valid_q[STAGES-1] || out_ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			stage_en[i] = !stage_valid_q[i] || stage_en[i+1];
		end
	end

	assign in_ready = stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_valid_q[0] <= in_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (stage_en[i]) begin
					stage_valid_q[i] <= stage_valid_q[i-1];
				end
			end
		end
	end

	assign window = WINDOW_BASE - {1'b0, heavy_row_count_q};
	assign cauchy_x = heavy_row_count_q + rem_s5;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			row_s1 <= row_num;
			col_s1 <= column_index;
			err_s1 <= {1'b0, row_num} >= heavy_row_count_q;
		end
		if (stage_en[1]) begin
			row_s2 <= row_s1;
			err_s2 <= err_s1;
			col_s2 <= col_s1[11:0];
			rem_s2 <= rem_digit(8'd0, col_s1[15:12], window);
		end
		if (stage_en[2]) begin
			row_s3 <= row_s2;
			err_s3 <= err_s2;
			col_s3 <= col_s2[7:0];
			rem_s3 <= rem_digit(rem_s2, col_s2[11:8], window);
		end
		if (stage_en[3]) begin
			row_s4 <= row_s3;
			err_s4 <= err_s3;
			col_s4 <= col_s3[3:0];
			rem_s4 <= rem_digit(rem_s3, col_s3[7:4], window);
		end
		if (stage_en[4]) begin
			row_s5 <= row_s4;
			err_s5 <= err_s4;
			rem_s5 <= rem_digit(rem_s4, col_s4, window);
		end
		if (stage_en[5]) begin
			err_s6 <= err_s5;
			inv_s6 <= INV_TAB[cauchy_x ^ {1'b0, row_s5}];
		end
		if (stage_en[6]) begin
			row_error_s7 <= err_s6;
			if (err_s6) begin
				coefficient_s7 <= 8'd0;
			end else if (coeff_family_q) begin
				coefficient_s7 <= hash_coef;
			end else begin
				coefficient_s7 <= inv_s6;
			end
		end
	end

	hrcg_hash u_hash (
		.clk          (clk),
		.stage_en     (stage_en[STAGES-2:0]),
		.row_num      (row_num),
		.column_index (column_index),
		.seed         (hash_seed_q),
		.hash_coef    (hash_coef)
	);

	assign out_valid = stage_valid_q[STAGES-1];
	assign coefficient = coefficient_s7;
	assign row_error = row_error_s7;

`ifndef SYNTHESIS
	a_err_zero_coef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_error |-> coefficient == 8'd0)
		else $error("row error item carries a nonzero coefficient");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid_q == '0 |-> in_ready)
		else $error("empty pipeline refuses an item");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stage_valid_q[0])
		else $error("accepted item missing from first stage");
`endif

endmodule
